// ----- rtl/pfx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfx_pkg
// Shared constants, status codes and types of the postfix expression evaluator.
// -----------------------------------------------------------------------------
package pfx_pkg;

   // stack geometry
   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

   // datapath widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned SYM_W    = 8;
   localparam int unsigned STATUS_W = 3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY_END = 3'd5;

   // symbol codes
   localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
   localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/pfx_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfx_req_if
// Request channel: one expression byte per request, with an end marker.
// -----------------------------------------------------------------------------
interface pfx_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfx_pkg::SYM_W-1:0]    symbol;
   logic                         last_symbol;

   modport source (output valid, symbol, last_symbol, input ready);
   modport sink   (input valid, symbol, last_symbol, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfx_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfx_rsp_if
// Result channel: expression value and first status code.
// -----------------------------------------------------------------------------
interface pfx_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [pfx_pkg::DATA_W-1:0] value;
   logic [pfx_pkg::STATUS_W-1:0]     status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfx_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfx_divider
// Signed 32-bit divider, one quotient bit per cycle (restoring, on magnitudes).
// Truncates toward zero; the most negative value over -1 wraps.
// -----------------------------------------------------------------------------
module pfx_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pfx_pkg::div_req_type div_req,
   output pfx_pkg::div_rsp_type      div_rsp
);

   localparam int unsigned DW   = pfx_pkg::DATA_W;
   localparam int unsigned STEP_W = $clog2(DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [DW:0]       shifted;
   logic [DW+1:0]     diff;
   logic              fits;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = ~diff[DW+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         // load magnitudes and remember the quotient sign
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend[DW-1] ? (DW'(0) - div_req.dividend) : div_req.dividend;
         dvs_in  = div_req.divisor[DW-1] ? (DW'(0) - div_req.divisor) : div_req.divisor;
         neg_in  = div_req.dividend[DW-1] ^ div_req.divisor[DW-1];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // restore the sign
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

endmodule
`default_nettype wire

// ----- rtl/postfix_expression_evaluator.sv -----
// Sequence: a request is taken in the idle state; an operand push, a divide by zero
// or an unknown symbol then passes EXEC and DONE, + - * pass EXEC, ARITH, WRITE and
// DONE, and / also waits in DIVIDE on the bit-serial divider. A new request is taken
// only back in idle; a final symbol also holds in DONE while the previous result waits.
// Reset: synchronous, active high; clears stack count, error record and the
// result flag. The stack memory is not cleared: entries above the count are never used.
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator: a sequencer over a 32-bit operand stack held in a
// synchronous memory, with the top entry mirrored in a register.
// -----------------------------------------------------------------------------
module postfix_expression_evaluator (
   input  wire logic  clock,
   input  wire logic  reset,
   pfx_req_if.sink    req_if,
   pfx_rsp_if.source  rsp_if
);

   localparam int unsigned DW   = pfx_pkg::DATA_W;
   localparam int unsigned AW   = pfx_pkg::ADDR_W;
   localparam int unsigned CW   = pfx_pkg::CNT_W;
   localparam int unsigned SW   = pfx_pkg::SYM_W;
   localparam int unsigned STW  = pfx_pkg::STATUS_W;
   localparam int unsigned DEPTH = pfx_pkg::STACK_DEPTH;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_ARITH  = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;
   logic [STW-1:0] err_ff, err_in;
   logic [DW-1:0] top_ff, top_in;
   logic [DW-1:0] opa_ff, opa_in;
   logic [DW-1:0] opb_ff, opb_in;
   logic [DW-1:0] res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff, rsp_value_in;
   logic [STW-1:0] rsp_status_ff, rsp_status_in;

   // stack memory
   logic [DW-1:0] stack_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   logic          req_take;
   logic          rsp_load;
   logic          is_operand;
   logic          is_operator;
   logic          count_nz;
   logic          count_ge2;
   logic [DW-1:0] push_val;

   pfx_pkg::div_req_type div_req;
   pfx_pkg::div_rsp_type div_rsp;

   // classify the held symbol
   assign is_operand = ((sym_ff >= pfx_pkg::CH_LO_A) && (sym_ff <= pfx_pkg::CH_LO_Z)) ||
                       ((sym_ff >= pfx_pkg::CH_UP_A) && (sym_ff <= pfx_pkg::CH_UP_Z)) ||
                       ((sym_ff >= pfx_pkg::CH_ZERO) && (sym_ff <= pfx_pkg::CH_NINE));
   assign is_operator = (sym_ff == pfx_pkg::CH_PLUS) || (sym_ff == pfx_pkg::CH_MINUS) ||
                        (sym_ff == pfx_pkg::CH_STAR) || (sym_ff == pfx_pkg::CH_SLASH);
   assign push_val  = {{(DW - SW){1'b0}}, sym_ff} - {{(DW - SW){1'b0}}, pfx_pkg::CH_ZERO};
   assign count_nz  = (count_ff != '0);
   assign count_ge2 = (count_ff >= CW'(2));

   // second entry from the top, read while the request is taken
   assign rd_addr  = AW'(count_ff - CW'(2));

   assign req_take      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);

   // divider hand-off
   assign div_req.start    = (state_ff == S_ARITH) && (sym_ff == pfx_pkg::CH_SLASH);
   assign div_req.dividend = opa_ff;
   assign div_req.divisor  = opb_ff;

   pfx_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      res_in        = res_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = push_val;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sym_in   = req_if.symbol;
               last_in  = req_if.last_symbol;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (is_operand) begin
               // push, or drop on a full stack
               if (count_ff == CW'(DEPTH)) begin
                  if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_OVER;
               end else begin
                  wr_en    = 1'b1;
                  top_in   = push_val;
                  count_in = count_ff + CW'(1);
               end
            end else if (!is_operator) begin
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_UNKNOWN;
            end else if ((sym_ff == pfx_pkg::CH_SLASH) && count_nz && (top_ff == '0)) begin
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_DIVZERO;
            end else begin
               // pop both operands; a missing one reads as all ones
               opb_in   = count_nz  ? top_ff     : '1;
               opa_in   = count_ge2 ? rd_data_ff : '1;
               count_in = count_ge2 ? (count_ff - CW'(2)) : '0;
               if (!count_ge2 && (err_ff == pfx_pkg::ST_OK)) err_in = pfx_pkg::ST_UNDER;
               state_in = S_ARITH;
            end
         end
         S_ARITH: begin
            state_in = S_WRITE;
            case (sym_ff)
               pfx_pkg::CH_PLUS:  res_in = opa_ff + opb_ff;
               pfx_pkg::CH_MINUS: res_in = opa_ff - opb_ff;
               pfx_pkg::CH_STAR:  res_in = opa_ff * opb_ff;
               default:           state_in = S_DIVIDE;
            endcase
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quotient;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // push the result; popping first leaves room
            wr_en    = 1'b1;
            wr_data  = res_ff;
            top_in   = res_ff;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               // hand out the result and start a fresh expression
               rsp_load      = 1'b1;
               rsp_value_in  = count_nz ? top_ff : '0;
               rsp_status_in = (count_nz || (err_ff != pfx_pkg::ST_OK)) ?
                               err_ff : pfx_pkg::ST_EMPTY_END;
               count_in      = '0;
               err_in        = pfx_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result flag: load wins over a completed take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= pfx_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      res_ff        <= res_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("stack count beyond depth");

   a_write_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("result write did not advance the count");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> ((count_ff == '0) && (err_ff == pfx_pkg::ST_OK) && rsp_valid_ff))
      else $error("expression end did not clear the stack");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      ((err_ff != pfx_pkg::ST_OK) && !rsp_load) |=> (err_ff == $past(err_ff)))
      else $error("first error overwritten");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide state");
`endif

endmodule
`default_nettype wire

// ----- dv/pfx_expr_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pfx_expr_checker
// Watches the request and result channels of the postfix evaluator, keeps its
// own operand stack and error record, and checks each result against the value
// and status worked out for the expression that produced it.
// -----------------------------------------------------------------------------
module pfx_expr_checker (
   input  logic clock,
   input  logic reset,
   pfx_req_if   req_mon,
   pfx_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_results
);

   typedef struct packed {
      logic [pfx_pkg::DATA_W-1:0]   value;
      logic [pfx_pkg::STATUS_W-1:0] status;
   } expr_result_type;

   logic [pfx_pkg::DATA_W-1:0]   operand_mem [pfx_pkg::STACK_DEPTH];
   int unsigned                  depth;
   logic [pfx_pkg::STATUS_W-1:0] first_err;
   expr_result_type              expr_results_q[$];
   int                           mismatch_total = 0;

   // keep only the first error of an expression
   function automatic void record_error(logic [pfx_pkg::STATUS_W-1:0] code);
      if (first_err == pfx_pkg::ST_OK) begin
         first_err = code;
      end
   endfunction

   // drop the value when the stack is full
   function automatic void push_operand(logic [pfx_pkg::DATA_W-1:0] v);
      if (depth >= pfx_pkg::STACK_DEPTH) begin
         record_error(pfx_pkg::ST_OVER);
      end else begin
         operand_mem[depth] = v;
         depth++;
      end
   endfunction

   // an empty stack reads as all ones
   function automatic logic [pfx_pkg::DATA_W-1:0] pop_operand();
      if (depth == 0) begin
         record_error(pfx_pkg::ST_UNDER);
         return '1;
      end
      depth--;
      return operand_mem[depth];
   endfunction

   // signed division toward zero; the most negative value over -1 wraps
   function automatic logic [pfx_pkg::DATA_W-1:0] quotient_toward_zero(
      logic [pfx_pkg::DATA_W-1:0] num, logic [pfx_pkg::DATA_W-1:0] den);
      if (num == {1'b1, {(pfx_pkg::DATA_W-1){1'b0}}} && den == '1) begin
         return num;
      end
      return $signed(num) / $signed(den);
   endfunction

   // apply one expression byte to the stack
   function automatic void evaluate_symbol(logic [pfx_pkg::SYM_W-1:0] sym);
      logic [pfx_pkg::DATA_W-1:0] lhs;
      logic [pfx_pkg::DATA_W-1:0] rhs;
      logic [pfx_pkg::DATA_W-1:0] res;
      if ((sym >= pfx_pkg::CH_ZERO && sym <= pfx_pkg::CH_NINE) ||
          (sym >= pfx_pkg::CH_LO_A && sym <= pfx_pkg::CH_LO_Z) ||
          (sym >= pfx_pkg::CH_UP_A && sym <= pfx_pkg::CH_UP_Z)) begin
         push_operand(pfx_pkg::DATA_W'(sym) - pfx_pkg::DATA_W'(pfx_pkg::CH_ZERO));
         return;
      end
      if (sym != pfx_pkg::CH_PLUS && sym != pfx_pkg::CH_MINUS &&
          sym != pfx_pkg::CH_STAR && sym != pfx_pkg::CH_SLASH) begin
         record_error(pfx_pkg::ST_UNKNOWN);
         return;
      end
      // a zero divisor on top leaves the stack untouched
      if (sym == pfx_pkg::CH_SLASH && depth != 0 && operand_mem[depth-1] == '0) begin
         record_error(pfx_pkg::ST_DIVZERO);
         return;
      end
      rhs = pop_operand();
      lhs = pop_operand();
      case (sym)
         pfx_pkg::CH_PLUS:  res = lhs + rhs;
         pfx_pkg::CH_MINUS: res = lhs - rhs;
         pfx_pkg::CH_STAR:  res = lhs * rhs;
         default:           res = quotient_toward_zero(lhs, rhs);
      endcase
      push_operand(res);
   endfunction

   // track requests, compare results
   always @(posedge clock) begin
      expr_result_type want;
      if (reset) begin
         depth     = 0;
         first_err = pfx_pkg::ST_OK;
         expr_results_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expr_results_q.size() == 0) begin
               $display("%0t: unexpected result value %0d status %0d", $time,
                        rsp_mon.value, rsp_mon.status);
               mismatch_total++;
            end else begin
               want = expr_results_q.pop_front();
               if (rsp_mon.value !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                           $signed(want.value), rsp_mon.value);
                  mismatch_total++;
               end
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                           want.status, rsp_mon.status);
                  mismatch_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            evaluate_symbol(req_mon.symbol);
            // close the expression: report top (zero if empty) and first error, then clear
            if (req_mon.last_symbol) begin
               if (depth != 0) begin
                  want.value  = operand_mem[depth-1];
                  want.status = first_err;
               end else begin
                  want.value  = '0;
                  want.status = (first_err != pfx_pkg::ST_OK) ? first_err :
                                pfx_pkg::ST_EMPTY_END;
               end
               expr_results_q.push_back(want);
               depth     = 0;
               first_err = pfx_pkg::ST_OK;
            end
         end
      end
      error_count     <= mismatch_total;
      pending_results <= expr_results_q.size();
   end

endmodule

// ----- dv/postfix_expression_evaluator_test.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// postfix_expression_evaluator_test
// Drives postfix expressions into the evaluator: a few hand-built ones for the
// arithmetic corner cases and error codes, then random well-formed expressions,
// broken byte strings and stack-filling runs, with random gaps on both sides.
// -----------------------------------------------------------------------------
module postfix_expression_evaluator_test;

   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned DRAIN_CYCLES = 60;

   // symbols without a name in the package
   localparam logic [pfx_pkg::SYM_W-1:0] SYM_NUL      = 8'h00;
   localparam logic [pfx_pkg::SYM_W-1:0] SYM_ALL_ONES = 8'hFF;
   localparam logic [pfx_pkg::SYM_W-1:0] SYM_ONE      = "1";
   localparam logic [pfx_pkg::SYM_W-1:0] SYM_TWO      = "2";
   localparam logic [pfx_pkg::SYM_W-1:0] SYM_LO_P     = "p";

   logic                      clock;
   logic                      reset;
   int                        fail_count;
   int                        pending_results;
   int                        random_items;
   int                        deep_runs;
   bit                        req_burst;
   bit                        rsp_burst;
   bit                        paused_once;
   logic [pfx_pkg::SYM_W-1:0] expr_q[$];

   pfx_req_if req_if ();
   pfx_rsp_if rsp_if ();

   postfix_expression_evaluator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   pfx_expr_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .error_count     (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic bit is_known(logic [pfx_pkg::SYM_W-1:0] s);
      return (s >= pfx_pkg::CH_ZERO && s <= pfx_pkg::CH_NINE) ||
             (s >= pfx_pkg::CH_LO_A && s <= pfx_pkg::CH_LO_Z) ||
             (s >= pfx_pkg::CH_UP_A && s <= pfx_pkg::CH_UP_Z) ||
             s == pfx_pkg::CH_PLUS || s == pfx_pkg::CH_MINUS ||
             s == pfx_pkg::CH_STAR || s == pfx_pkg::CH_SLASH;
   endfunction

   // digits, both letter cases, and an extra share of zeros for divide by zero
   function automatic logic [pfx_pkg::SYM_W-1:0] random_operand();
      case ($urandom_range(0, 7))
         0, 1, 2: return pfx_pkg::CH_ZERO + pfx_pkg::SYM_W'($urandom_range(0, 9));
         3, 4:    return pfx_pkg::CH_LO_A + pfx_pkg::SYM_W'($urandom_range(0, 25));
         5, 6:    return pfx_pkg::CH_UP_A + pfx_pkg::SYM_W'($urandom_range(0, 25));
         default: return pfx_pkg::CH_ZERO;
      endcase
   endfunction

   function automatic logic [pfx_pkg::SYM_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return pfx_pkg::CH_PLUS;
         1:       return pfx_pkg::CH_MINUS;
         2:       return pfx_pkg::CH_STAR;
         default: return pfx_pkg::CH_SLASH;
      endcase
   endfunction

   // hold valid across back-to-back requests; lower it only for a gap
   task automatic send_symbol(input logic [pfx_pkg::SYM_W-1:0] sym, input logic last);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.symbol      <= sym;
      req_if.last_symbol <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_expression(input bit counted);
      foreach (expr_q[i]) begin
         send_symbol(expr_q[i], i == expr_q.size() - 1);
         if (counted && is_known(expr_q[i])) begin
            random_items++;
         end
      end
   endtask

   // drop valid and hold off until every result is back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // result side: random stalls with bursts of none
   initial begin
      int stall;
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_burst = !rsp_burst;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // request side
   initial begin
      int kind;
      int ops_left;
      int pushes_left;
      int live;
      int count;
      req_if.valid       <= 1'b0;
      req_if.symbol      <= SYM_NUL;
      req_if.last_symbol <= 1'b0;
      reset              <= 1'b1;
      random_items = 0;
      deep_runs    = 0;
      paused_once  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // unknown bytes at both ends, letter and digit bounds, negative quotient
      expr_q = '{SYM_NUL, pfx_pkg::CH_LO_Z, pfx_pkg::CH_UP_Z, pfx_pkg::CH_PLUS,
                 pfx_pkg::CH_ZERO, pfx_pkg::CH_NINE, pfx_pkg::CH_MINUS,
                 pfx_pkg::CH_SLASH, SYM_ALL_ONES};
      send_expression(1'b0);
      // divide by zero
      expr_q = '{pfx_pkg::CH_UP_A, pfx_pkg::CH_ZERO, pfx_pkg::CH_SLASH};
      send_expression(1'b0);
      // pop from an empty stack
      expr_q = '{pfx_pkg::CH_LO_A, pfx_pkg::CH_MINUS};
      send_expression(1'b0);
      // most negative value over minus one
      expr_q = '{SYM_LO_P, SYM_LO_P, pfx_pkg::CH_STAR, SYM_LO_P, pfx_pkg::CH_STAR,
                 SYM_LO_P, pfx_pkg::CH_STAR, SYM_LO_P, pfx_pkg::CH_STAR, SYM_TWO,
                 pfx_pkg::CH_STAR, pfx_pkg::CH_ZERO, SYM_ONE, pfx_pkg::CH_MINUS,
                 pfx_pkg::CH_SLASH};
      send_expression(1'b0);
      wait_for_results();

      while (random_items < RANDOM_ITEMS) begin
         req_burst = ($urandom_range(0, 4) == 0);
         expr_q.delete();
         kind = $urandom_range(0, 99);
         if ((deep_runs < 2 && random_items >= 150 * (deep_runs + 1)) ||
             (kind < 2 && deep_runs < 4)) begin
            // fill the stack to the brim and often past it
            count = $urandom_range(62, 70);
            repeat (count) expr_q.push_back(random_operand());
            count = $urandom_range(0, 8);
            repeat (count) expr_q.push_back(random_operator());
            deep_runs++;
         end else if (kind < 78) begin
            // well-formed expression that folds down to one value
            ops_left    = $urandom_range(0, 10);
            pushes_left = ops_left + 1;
            live        = 0;
            while (pushes_left > 0 || ops_left > 0) begin
               if (live >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1))) begin
                  expr_q.push_back(random_operator());
                  ops_left--;
                  live--;
               end else begin
                  expr_q.push_back(random_operand());
                  pushes_left--;
                  live++;
               end
            end
         end else begin
            // broken strings: arbitrary bytes and short stacks
            count = $urandom_range(1, 8);
            repeat (count) begin
               case ($urandom_range(0, 3))
                  0:       expr_q.push_back(pfx_pkg::SYM_W'($urandom_range(0, 255)));
                  1:       expr_q.push_back(random_operand());
                  default: expr_q.push_back(random_operator());
               endcase
            end
         end
         send_expression(1'b1);
         if (!paused_once && random_items >= RANDOM_ITEMS / 2) begin
            wait_for_results();
            paused_once = 1'b1;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
